>>> rtl/uvg_pkg.sv
package uvg_pkg;

    localparam int unsigned SEC_W      = 39;
    localparam int unsigned NS_W       = 30;
    localparam int unsigned RESEED_W   = 20;
    localparam int unsigned TAIL_W     = 40;
    localparam int unsigned CNT_W      = 22;
    localparam int unsigned MS_W       = 48;
    localparam int unsigned FRAC_W     = 12;
    localparam int unsigned LIMIT_W    = 32;
    localparam int unsigned UUID_W     = 64;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 2;

    localparam int unsigned NSTG       = 6;

    // Widths of the intermediate values of the timestamp arithmetic.
    localparam int unsigned Q_W        = 11;
    localparam int unsigned QPROD_W    = NS_W + Q_W;
    localparam int unsigned QNS_W      = NS_W + 1;
    localparam int unsigned REM0_W     = 21;
    localparam int unsigned R_W        = 20;
    localparam int unsigned F_PRESHIFT = 6;
    localparam int unsigned X_W        = R_W + F_PRESHIFT;
    localparam int unsigned FPROD_W    = 32;
    localparam int unsigned FREM_W     = 15;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(60 * 60 * 48);
    localparam logic [19:0]        NS_PER_MS   = 20'd1000000;
    localparam logic [9:0]         MS_PER_SEC  = 10'd1000;

    // The quotient by one million comes from floor(2^30 / 1e6), which is low by
    // at most one for any 30-bit value, so a single correction step follows.
    localparam logic [10:0]        Q_RECIP     = 11'd1073;
    localparam int unsigned        Q_SHIFT     = 30;

    // The fraction is floor(r * 64 / 15625); the reciprocal floor(2^26 / 15625)
    // is likewise low by at most one.
    localparam logic [12:0]        F_RECIP     = 13'd4294;
    localparam int unsigned        F_SHIFT     = 26 - F_PRESHIFT;
    localparam logic [13:0]        F_DIV       = 14'd15625;

    localparam logic [3:0]         UUID_VERSION = 4'h7;
    localparam logic [1:0]         UUID_VARIANT = 2'b10;

    localparam logic [APB_ADDR_W-1:0] ADDR_ROLLBACK_LIMIT = APB_ADDR_W'(0);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FAULT    = 2'd1,
        ST_ROLLBACK = 2'd2
    } t_status;

    typedef struct packed {
        logic [SEC_W-1:0]    sec;
        logic [NS_W-1:0]     ns;
        logic                fault;
        logic [RESEED_W-1:0] reseed;
        logic [TAIL_W-1:0]   tail;
    } t_req;

    typedef struct packed {
        logic [MS_W-1:0]   ms;
        logic [FRAC_W-1:0] f0;
        logic [FREM_W-1:0] rem;
        t_req              req;
    } t_stamp;

endpackage

>>> rtl/uvg_cfg.sv
module uvg_cfg
    import uvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [LIMIT_W-1:0]    o_limit
);

    logic [LIMIT_W-1:0] r_limit;
    logic               w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && (paddr == ADDR_ROLLBACK_LIMIT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= LIMIT_RESET;
        end else if (w_wr) begin
            r_limit <= LIMIT_W'(pwdata);
        end
    end

    always_comb begin
        prdata = '0;
        unique case (paddr)
            ADDR_ROLLBACK_LIMIT: prdata = APB_DATA_W'(r_limit);
            default:             prdata = '0;
        endcase
    end

    assign o_limit = r_limit;

endmodule

>>> rtl/uvg_ts_math.sv
module uvg_ts_math
    import uvg_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_req   i_req,
    output logic   o_valid,
    input  logic   i_ready,
    output t_stamp o_stamp
);

    logic [NSTG-1:0]   r_v;
    logic [NSTG-1:0]   w_rdy;

    t_req              r_req0, r_req1, r_req2, r_req3, r_req4, r_req5;
    logic [Q_W-1:0]    r_q1, r_q2;
    logic [MS_W-1:0]   r_sms1, r_sms2, r_ms3, r_ms4, r_ms5;
    logic [REM0_W-1:0] r_rem0_2;
    logic [R_W-1:0]    r_r3, r_r4;
    logic [FRAC_W-1:0] r_f0_4, r_f0_5;
    logic [FREM_W-1:0] r_frem5;

    logic [QPROD_W-1:0] w_qprod;
    logic [Q_W-1:0]     w_q0;
    logic [MS_W-1:0]    w_sms;
    logic [QNS_W-1:0]   w_qns;
    logic [REM0_W-1:0]  w_rem0;
    logic               w_fix;
    logic [Q_W-1:0]     w_q;
    logic [R_W-1:0]     w_r;
    logic [MS_W-1:0]    w_ms;
    logic [FPROD_W-1:0] w_fprod;
    logic [FRAC_W-1:0]  w_f0;
    logic [X_W-1:0]     w_x;

    always_comb begin
        w_rdy[NSTG-1] = !r_v[NSTG-1] || i_ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Stage 1: estimated quotient by one million and seconds times 1000.
    assign w_qprod = QPROD_W'(r_req0.ns) * QPROD_W'(Q_RECIP);
    assign w_q0    = w_qprod[Q_SHIFT +: Q_W];
    assign w_sms   = MS_W'(r_req0.sec) * MS_W'(MS_PER_SEC);

    // Stage 2: remainder of the estimate, below two million.
    assign w_qns  = QNS_W'(r_q1) * QNS_W'(NS_PER_MS);
    assign w_rem0 = REM0_W'(QNS_W'(r_req1.ns) - w_qns);

    // Stage 3: correct the quotient and form the millisecond count.
    assign w_fix = (r_rem0_2 >= REM0_W'(NS_PER_MS));
    assign w_q   = w_fix ? (r_q2 + Q_W'(1)) : r_q2;
    assign w_r   = w_fix ? R_W'(r_rem0_2 - REM0_W'(NS_PER_MS)) : R_W'(r_rem0_2);
    assign w_ms  = r_sms2 + MS_W'(w_q);

    // Stage 4: estimated 12-bit fraction.
    assign w_fprod = FPROD_W'(r_r3) * FPROD_W'(F_RECIP);
    assign w_f0    = w_fprod[F_SHIFT +: FRAC_W];

    // Stage 5: remainder of the fraction estimate, below twice the divisor.
    assign w_x = (X_W'(r_r4) << F_PRESHIFT) - X_W'(r_f0_4) * X_W'(F_DIV);

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_req0 <= i_req;
        end
        if (w_rdy[1]) begin
            r_req1 <= r_req0;
            r_q1   <= w_q0;
            r_sms1 <= w_sms;
        end
        if (w_rdy[2]) begin
            r_req2   <= r_req1;
            r_q2     <= r_q1;
            r_sms2   <= r_sms1;
            r_rem0_2 <= w_rem0;
        end
        if (w_rdy[3]) begin
            r_req3 <= r_req2;
            r_ms3  <= w_ms;
            r_r3   <= w_r;
        end
        if (w_rdy[4]) begin
            r_req4 <= r_req3;
            r_ms4  <= r_ms3;
            r_r4   <= r_r3;
            r_f0_4 <= w_f0;
        end
        if (w_rdy[5]) begin
            r_req5  <= r_req4;
            r_ms5   <= r_ms4;
            r_f0_5  <= r_f0_4;
            r_frem5 <= FREM_W'(w_x);
        end
    end

    always_comb begin
        o_stamp.ms  = r_ms5;
        o_stamp.f0  = r_f0_5;
        o_stamp.rem = r_frem5;
        o_stamp.req = r_req5;
    end

endmodule

>>> rtl/uvg_seq.sv
module uvg_seq
    import uvg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  t_stamp             i_stamp,
    input  logic [LIMIT_W-1:0] i_limit,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [UUID_W-1:0]  o_uuid_high,
    output logic [UUID_W-1:0]  o_uuid_low,
    output logic [1:0]         o_status
);

    logic [SEC_W-1:0]  r_last_sec, n_last_sec;
    logic [NS_W-1:0]   r_last_ns, n_last_ns;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_valid;
    logic [UUID_W-1:0] r_high, n_high;
    logic [UUID_W-1:0] r_low, n_low;
    t_status           r_status, n_status;

    logic              w_take;
    logic              w_newer;
    logic              w_window;
    logic [SEC_W:0]    w_sum;
    logic [FRAC_W-1:0] w_frac;

    assign o_ready = !r_valid || !i_stall;
    assign w_take  = i_valid && o_ready;

    assign w_newer  = (i_stamp.req.sec > r_last_sec) ||
                      ((i_stamp.req.sec == r_last_sec) && (i_stamp.req.ns > r_last_ns));
    assign w_sum    = (SEC_W + 1)'(i_stamp.req.sec) + (SEC_W + 1)'(i_limit);
    assign w_window = w_sum > (SEC_W + 1)'(r_last_sec);
    assign w_frac   = (i_stamp.rem >= FREM_W'(F_DIV)) ? (i_stamp.f0 + FRAC_W'(1)) : i_stamp.f0;

    always_comb begin
        n_last_sec = r_last_sec;
        n_last_ns  = r_last_ns;
        n_cnt      = r_cnt;
        n_status   = ST_OK;
        n_high     = '0;
        n_low      = '0;
        if (i_stamp.req.fault) begin
            n_status = ST_FAULT;
        end else if (w_newer || w_window) begin
            if (w_newer) begin
                n_last_sec = i_stamp.req.sec;
                n_last_ns  = i_stamp.req.ns;
                n_cnt      = CNT_W'(i_stamp.req.reseed);
            end else begin
                n_cnt = r_cnt + CNT_W'(1);
            end
            n_high = {i_stamp.ms, UUID_VERSION, w_frac};
            n_low  = {UUID_VARIANT, n_cnt, i_stamp.req.tail};
        end else begin
            n_status = ST_ROLLBACK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_sec <= '0;
            r_last_ns  <= '0;
            r_cnt      <= '0;
            r_valid    <= 1'b0;
            r_status   <= ST_OK;
        end else begin
            if (w_take) begin
                r_last_sec <= n_last_sec;
                r_last_ns  <= n_last_ns;
                r_cnt      <= n_cnt;
                r_status   <= n_status;
            end
            if (o_ready) begin
                r_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_high <= n_high;
            r_low  <= n_low;
        end
    end

    assign o_valid     = r_valid;
    assign o_uuid_high = r_high;
    assign o_uuid_low  = r_low;
    assign o_status    = r_status;

endmodule

>>> rtl/uuid_v7_monotonic_generator.sv
// UUID version 7 generator with a monotonic 22-bit sequence counter.
//
// Input channel: i_in_valid with o_in_stall carries one request item
// (seconds, nanoseconds, clock fault flag, 20 reseed bits, 40 tail bits).
// Output channel: o_out_valid with i_out_stall carries one result item per
// request: the two 64-bit UUID words and a status (ok, clock fault, or time
// stepped back beyond the limit, where both words are zero).
// The rollback limit is a 32-bit register at APB address 0; write it only
// while no item is in flight.
// An accepted item passes six registered math stages, then the result
// register. One item is accepted in every cycle while o_in_stall is low.
// The divisions by one million run as six registered stages of constant
// multiplies. The last stage holds the timestamp compare and counter update,
// one item per cycle while not stalled. A stall on the output holds the
// result register; items enter until all stages fill, then o_in_stall rises.
// Reset clears all items in flight, the stored timestamp and the counter,
// and loads the rollback limit with 172800 seconds.
module uuid_v7_monotonic_generator
    import uvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SEC_W-1:0]      i_time_seconds,
    input  logic [NS_W-1:0]       i_time_nanos,
    input  logic                  i_clock_fault,
    input  logic [RESEED_W-1:0]   i_reseed_value,
    input  logic [TAIL_W-1:0]     i_random_tail,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [UUID_W-1:0]     o_uuid_high,
    output logic [UUID_W-1:0]     o_uuid_low,
    output logic [1:0]            o_status,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_req               w_req;
    t_stamp             w_stamp;
    logic               w_in_ready;
    logic               w_stamp_valid;
    logic               w_stamp_ready;
    logic [LIMIT_W-1:0] w_limit;

    always_comb begin
        w_req.sec    = i_time_seconds;
        w_req.ns     = i_time_nanos;
        w_req.fault  = i_clock_fault;
        w_req.reseed = i_reseed_value;
        w_req.tail   = i_random_tail;
    end

    assign o_in_stall = !w_in_ready;

    uvg_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_limit (w_limit)
    );

    uvg_ts_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (w_in_ready),
        .i_req   (w_req),
        .o_valid (w_stamp_valid),
        .i_ready (w_stamp_ready),
        .o_stamp (w_stamp)
    );

    uvg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stamp_valid),
        .o_ready     (w_stamp_ready),
        .i_stamp     (w_stamp),
        .i_limit     (w_limit),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_uuid_high (o_uuid_high),
        .o_uuid_low  (o_uuid_low),
        .o_status    (o_status)
    );

endmodule

>>> rtl/uvg_checker.sv
module uvg_checker
    import uvg_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [UUID_W-1:0]     o_uuid_high,
    input logic [UUID_W-1:0]     o_uuid_low,
    input logic [1:0]            o_status
);

    // A result that waits must not change until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_uuid_high) &&
            $stable(o_uuid_low) && $stable(o_status))
        else $error("output item changed while stalled");

    // Rejected requests carry an all-zero identifier.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> (o_uuid_high == '0) && (o_uuid_low == '0))
        else $error("rejected item carries a nonzero identifier");

    // Accepted requests carry the version and variant marks.
    a_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_OK) |->
            (o_uuid_high[15:12] == UUID_VERSION) && (o_uuid_low[63:62] == UUID_VARIANT))
        else $error("identifier lacks version or variant bits");

    // With nothing waiting at the output, the pipeline must take new items.
    a_drain: assert property (@(posedge i_clk)
        $past(!i_rst_n) || !o_out_valid |-> !o_in_stall || !i_rst_n)
        else $error("input stalled while the output is empty");

endmodule

bind uuid_v7_monotonic_generator uvg_checker u_uvg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_uuid_high (o_uuid_high),
    .o_uuid_low  (o_uuid_low),
    .o_status    (o_status)
);
